// File: rtl/core/lpr_pkg.sv
// Shared types and constants for the longest-prefix route lookup engine.
// Used by lpr_front, lpr_queue, lpr_back, the top level and the checker.
`default_nettype none

package lpr_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_TABLE_ENTRIES = 1024;
  localparam int DEF_PORT_BITS     = 4;

  // Fixed field widths
  localparam int ADDR_W = 32;
  localparam int SLOT_W = 10;
  localparam int PORT_W = 4;
  localparam int CFG_W  = 11;

  // Input tdata layout, lowest bit first
  localparam int IN_SLOT_LO   = 0;
  localparam int IN_PREFIX_LO = IN_SLOT_LO + SLOT_W;
  localparam int IN_MASK_LO   = IN_PREFIX_LO + ADDR_W;
  localparam int IN_HOP_LO    = IN_MASK_LO + ADDR_W;
  localparam int IN_PORT_LO   = IN_HOP_LO + ADDR_W;
  localparam int IN_DEST_LO   = IN_PORT_LO + PORT_W;
  localparam int IN_USED_W    = IN_DEST_LO + ADDR_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int OUT_HOP_LO  = 0;
  localparam int OUT_PORT_LO = OUT_HOP_LO + ADDR_W;
  localparam int OUT_MASK_LO = OUT_PORT_LO + PORT_W;
  localparam int OUT_USED_W  = OUT_MASK_LO + ADDR_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // Item kind carried in tuser
  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  // Decoded item passed from front to back
  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   entry_index;
    logic [ADDR_W-1:0]   route_prefix;
    logic [ADDR_W-1:0]   route_mask;
    logic [ADDR_W-1:0]   hop_address;
    logic [PORT_W-1:0]   port_number;
    logic [ADDR_W-1:0]   dest_addr;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/lpr_front.sv
// Front end: unpacks input items, drops writes to slots beyond the table.
// Depends on lpr_pkg.
`default_nettype none

module lpr_front #(
  parameter int TABLE_ENTRIES = lpr_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_index, route_prefix, route_mask, hop_address, port_number, dest_addr
  input  wire logic [lpr_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // kind
  input  wire logic [0:0]                   s_axis_tuser,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output lpr_pkg::cmd_t                     push_cmd
);
  import lpr_pkg::*;

  logic in_range;

  // Field unpack
  always_comb begin
    push_cmd.kind         = kind_t'(s_axis_tuser[0]);
    push_cmd.entry_index  = s_axis_tdata[IN_SLOT_LO +: SLOT_W];
    push_cmd.route_prefix = s_axis_tdata[IN_PREFIX_LO +: ADDR_W];
    push_cmd.route_mask   = s_axis_tdata[IN_MASK_LO +: ADDR_W];
    push_cmd.hop_address  = s_axis_tdata[IN_HOP_LO +: ADDR_W];
    push_cmd.port_number  = s_axis_tdata[IN_PORT_LO +: PORT_W];
    push_cmd.dest_addr    = s_axis_tdata[IN_DEST_LO +: ADDR_W];
  end

  // Writes past the table end are taken and dropped
  assign in_range      = 32'(push_cmd.entry_index) < 32'(TABLE_ENTRIES);
  assign s_axis_tready = push_ready;
  assign push_valid    = s_axis_tvalid &&
                         ((push_cmd.kind == KIND_LOOKUP) || in_range);

endmodule

`default_nettype wire

// File: rtl/core/lpr_queue.sv
// Two-entry command queue between front and back.
// Depends on lpr_pkg.
`default_nettype none

module lpr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  lpr_pkg::cmd_t      push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output lpr_pkg::cmd_t      pop_cmd
);
  import lpr_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       slots [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = count != 2'(DEPTH);
  assign pop_valid  = count != 2'd0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lpr_back.sv
// Back end: route table memories, linear scan with best-match tracking,
// and the result output register. Depends on lpr_pkg.
`default_nettype none

module lpr_back #(
  parameter int TABLE_ENTRIES = lpr_pkg::DEF_TABLE_ENTRIES,
  parameter int PORT_BITS     = lpr_pkg::DEF_PORT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [lpr_pkg::CFG_W-1:0]     entries_in_use,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  lpr_pkg::cmd_t                      pop_cmd,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // best_next_hop, best_port, best_mask
  output logic [lpr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // found
  output logic [0:0]                         m_axis_tuser
);
  import lpr_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // Route table
  logic [ADDR_W-1:0]    prefix_mem [TABLE_ENTRIES];
  logic [ADDR_W-1:0]    mask_mem   [TABLE_ENTRIES];
  logic [ADDR_W-1:0]    hop_mem    [TABLE_ENTRIES];
  logic [PORT_BITS-1:0] port_mem   [TABLE_ENTRIES];

  state_t               state;
  state_t               state_next;
  logic [CNT_W-1:0]     rd_cnt;
  logic [CNT_W-1:0]     limit;
  logic                 rd_vld;
  logic [ADDR_W-1:0]    dest;
  logic [ADDR_W-1:0]    prefix_q;
  logic [ADDR_W-1:0]    mask_q;
  logic [ADDR_W-1:0]    hop_q;
  logic [PORT_BITS-1:0] port_q;
  logic                 hit;
  logic [ADDR_W-1:0]    best_mask;
  logic [ADDR_W-1:0]    best_hop;
  logic [PORT_BITS-1:0] best_port;
  logic                 out_valid;
  logic                 out_found;
  logic [ADDR_W-1:0]    out_hop;
  logic [PORT_W-1:0]    out_port;
  logic [ADDR_W-1:0]    out_mask;
  logic                 take_cmd;
  logic                 start_lookup;
  logic                 scan_end;
  logic                 out_free;
  logic                 load_out;
  logic                 better;
  logic [31:0]          limit_raw;

  assign pop_ready    = state == ST_IDLE;
  assign take_cmd     = pop_valid && pop_ready;
  assign start_lookup = take_cmd && (pop_cmd.kind == KIND_LOOKUP);
  assign scan_end     = (rd_cnt == limit) && !rd_vld;
  assign out_free     = !out_valid || m_axis_tready;
  assign load_out     = (state == ST_DONE) && out_free;
  assign better       = rd_vld && ((dest & mask_q) == prefix_q) &&
                        (!hit || (mask_q > best_mask));

  // Scan length saturates at the table size
  assign limit_raw = (32'(entries_in_use) > 32'(TABLE_ENTRIES)) ?
                     32'(TABLE_ENTRIES) : 32'(entries_in_use);

  // Sequencer
  always_comb begin
    case (state)
      ST_IDLE: state_next = start_lookup ? ST_SCAN : ST_IDLE;
      ST_SCAN: state_next = scan_end ? ST_DONE : ST_SCAN;
      ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Table write port and registered read port
  always_ff @(posedge clk) begin
    if (take_cmd && (pop_cmd.kind == KIND_WRITE)) begin
      prefix_mem[IDX_W'(pop_cmd.entry_index)] <= pop_cmd.route_prefix;
      mask_mem[IDX_W'(pop_cmd.entry_index)]   <= pop_cmd.route_mask;
      hop_mem[IDX_W'(pop_cmd.entry_index)]    <= pop_cmd.hop_address;
      port_mem[IDX_W'(pop_cmd.entry_index)]   <= PORT_BITS'(pop_cmd.port_number);
    end
    prefix_q <= prefix_mem[rd_cnt[IDX_W-1:0]];
    mask_q   <= mask_mem[rd_cnt[IDX_W-1:0]];
    hop_q    <= hop_mem[rd_cnt[IDX_W-1:0]];
    port_q   <= port_mem[rd_cnt[IDX_W-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_cnt    <= '0;
      rd_vld    <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start_lookup) begin
        rd_cnt <= '0;
        rd_vld <= 1'b0;
        hit    <= 1'b0;
      end else if (state == ST_SCAN) begin
        rd_vld <= rd_cnt != limit;
        if (rd_cnt != limit) rd_cnt <= CNT_W'(rd_cnt + 1'b1);
        if (better) hit <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Lookup payload, best match and result register
  always_ff @(posedge clk) begin
    if (start_lookup) begin
      dest  <= pop_cmd.dest_addr;
      limit <= CNT_W'(limit_raw);
    end
    if ((state == ST_SCAN) && better) begin
      best_mask <= mask_q;
      best_hop  <= hop_q;
      best_port <= port_q;
    end
    if (load_out) begin
      out_found <= hit;
      out_hop   <= hit ? best_hop : '0;
      out_port  <= hit ? PORT_W'(best_port) : '0;
      out_mask  <= hit ? best_mask : '0;
    end
  end

  // Output pack
  always_comb begin
    m_axis_tdata                          = '0;
    m_axis_tdata[OUT_HOP_LO +: ADDR_W]    = out_hop;
    m_axis_tdata[OUT_PORT_LO +: PORT_W]   = out_port;
    m_axis_tdata[OUT_MASK_LO +: ADDR_W]   = out_mask;
  end
  assign m_axis_tvalid   = out_valid;
  assign m_axis_tuser[0] = out_found;

endmodule

`default_nettype wire

// File: rtl/core/longest_prefix_route_lookup.sv
// Longest-prefix route lookup engine: top level.
// Instantiates lpr_front, lpr_queue and lpr_back; depends on lpr_pkg.
// Usage:
//   s_axis carries items; tuser[0] is the kind (write or lookup). A write
//   stores prefix, mask, next hop and port at entry_index and gives no
//   result; writes to a slot past the table are taken and dropped. A
//   lookup scans slots 0 .. min(entries_in_use, TABLE_ENTRIES)-1 and gives
//   one result on m_axis: tuser[0] = found, tdata = hop, port, mask (zeros
//   when nothing matched). The longest mask wins, earliest slot on a tie.
//   cfg_valid/cfg_data write entries_in_use; cfg_ready is always high.
// Sequencing:
//   A write is taken by the back end in ST_IDLE and leaves it there. A
//   lookup moves the back end from ST_IDLE to ST_SCAN, where the single
//   table read port, one slot per cycle, reads the scanned slots in order,
//   then to ST_DONE until the output register is free for its result.
//   No new item leaves the queue until then. A two-entry queue keeps
//   s_axis taking items while the back end scans or the output is stalled.
// Reset (rst, synchronous) empties the queue, clears the output valid and
//   sets entries_in_use to 0; table contents are kept. A stalled result
//   holds, the back end waits, the queue fills and s_axis_tready drops.
`default_nettype none

module longest_prefix_route_lookup #(
  parameter int TABLE_ENTRIES = lpr_pkg::DEF_TABLE_ENTRIES,
  parameter int PORT_BITS     = lpr_pkg::DEF_PORT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  // entries_in_use
  input  wire logic [lpr_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // entry_index, route_prefix, route_mask, hop_address, port_number, dest_addr
  input  wire logic [lpr_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // kind
  input  wire logic [0:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // best_next_hop, best_port, best_mask
  output logic [lpr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // found
  output logic [0:0]                         m_axis_tuser
);
  import lpr_pkg::*;

  logic [CFG_W-1:0] entries_in_use;
  logic             push_valid;
  logic             push_ready;
  cmd_t             push_cmd;
  logic             pop_valid;
  logic             pop_ready;
  cmd_t             pop_cmd;

  // Scan length register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use <= cfg_data;
    end
  end

  lpr_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd)
  );

  lpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lpr_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PORT_BITS     (PORT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .entries_in_use (entries_in_use),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_cmd        (pop_cmd),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/core/lpr_checker.sv
// Port-level checks on the route lookup result channel, bound to the top.
// Depends on lpr_pkg.
`default_nettype none

module lpr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [lpr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [0:0]                    m_axis_tuser
);
  import lpr_pkg::*;

  // A stalled result holds its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A miss reports all-zero hop, port and mask
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss with nonzero result fields");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Result valid is always a known level out of reset
  a_valid_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(m_axis_tvalid))
    else $error("result valid unknown");

endmodule

bind longest_prefix_route_lookup lpr_checker u_lpr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
